// ----- hw/rtl/josephus_survivor_defines.svh -----
// Assertion macros shared by the josephus survivor RTL.
`ifndef JOSEPHUS_SURVIVOR_DEFINES_SVH
`define JOSEPHUS_SURVIVOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define JS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define JS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/js_pkg.sv -----
// Shared widths, queue sizing and status type for the josephus survivor block.
package js_pkg;

    localparam int PEOPLE_W    = 13;
    localparam int STEP_W      = 16;
    localparam int SURV_W      = 13;
    localparam int REQ_W       = PEOPLE_W + STEP_W;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int QADDR_W     = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_stat;

endpackage

// ----- hw/rtl/josephus_survivor.sv -----
// Josephus survivor: request queue in memory, recurrence sequencer and output register.
//
// Slave channel (i_s_*): one request per handshake, people count and step count.
// Master channel (o_m_*): one result per request, the one-based survivor number,
// in request order.
// Requests are written into a 16-entry queue memory; o_s_tready is low only when
// it is full, so requests keep arriving while an earlier one is being worked on.
// Each request runs the recurrence j = (j + k) mod i for i = 2 .. n. A step whose
// sum is already below i needs no division; otherwise the bit-serial remainder unit
// reduces the sum one bit per cycle (17 bits at the default size).
// Requests are worked on one at a time; the next is read from the queue once
// the current result has been handed to the output register.
// A people count of 0 is taken as 1, a step of 0 as 1, and a count above
// MAX_PEOPLE as MAX_PEOPLE.
// The result waits in the output register while i_m_tready is low; the next
// request is computed meanwhile and held until the register frees.
// Synchronous active-low reset empties the queue and drops any result in flight.
`include "josephus_survivor_defines.svh"

module josephus_survivor #(
    parameter int MAX_PEOPLE = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [12:0] people_count, [28:13] step_count, [31:29] zero
    input  logic [js_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [12:0] survivor, [15:13] zero
    output logic [js_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);

    localparam int JW = $clog2(MAX_PEOPLE);
    localparam int IW = $clog2(MAX_PEOPLE + 1);
    localparam int SW = ((JW > js_pkg::STEP_W) ? JW : js_pkg::STEP_W) + 1;
    localparam int NW = (IW > js_pkg::PEOPLE_W) ? IW : js_pkg::PEOPLE_W;
    localparam int PW = js_pkg::QADDR_W + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_ITER = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [js_pkg::REQ_W-1:0] q_mem [js_pkg::QUEUE_DEPTH];
    logic [js_pkg::REQ_W-1:0] r_q_rdata;
    logic [PW-1:0]            r_wr_ptr;
    logic [PW-1:0]            r_rd_ptr;
    logic [PW-1:0]            n_rd_ptr;

    logic [2:0]               r_state;
    logic [2:0]               n_state;
    logic [IW-1:0]            r_n;
    logic [IW-1:0]            n_n;
    logic [js_pkg::STEP_W-1:0] r_k;
    logic [js_pkg::STEP_W-1:0] n_k;
    logic [IW-1:0]            r_i;
    logic [IW-1:0]            n_i;
    logic [JW-1:0]            r_j;
    logic [JW-1:0]            n_j;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic [js_pkg::SURV_W-1:0] r_out_data;
    logic [js_pkg::SURV_W-1:0] n_out_data;

    logic                     w_s_acc;
    logic                     w_m_acc;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_rd_en;
    logic                     w_start;
    logic                     w_adv;
    logic [JW-1:0]            w_adv_j;
    logic [SW-1:0]            w_sum;
    logic                     w_sum_lt;
    logic [js_pkg::PEOPLE_W-1:0] w_people;
    logic [js_pkg::STEP_W-1:0] w_step;
    logic [NW-1:0]            w_n_ext;
    logic [IW-1:0]            w_n_eff;
    logic [IW-1:0]            w_surv;
    logic [IW-1:0]            w_rem;
    js_pkg::t_mod_stat        w_stat;

    assign w_full  = (r_wr_ptr[PW-1] != r_rd_ptr[PW-1]) &&
                     (r_wr_ptr[PW-2:0] == r_rd_ptr[PW-2:0]);
    assign w_empty = (r_wr_ptr == r_rd_ptr);
    assign o_s_tready = !w_full;
    assign w_s_acc = i_s_tvalid && !w_full;
    assign w_m_acc = r_out_valid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            q_mem[r_wr_ptr[PW-2:0]] <= i_s_tdata[js_pkg::REQ_W-1:0];
        end
        if (w_rd_en) begin
            r_q_rdata <= q_mem[r_rd_ptr[PW-2:0]];
        end
    end

    assign w_people = r_q_rdata[js_pkg::PEOPLE_W-1:0];
    assign w_step   = r_q_rdata[js_pkg::REQ_W-1:js_pkg::PEOPLE_W];

    always_comb begin
        w_n_ext = NW'(w_people);
        if (w_n_ext == '0) begin
            w_n_ext = NW'(1);
        end
        if (w_n_ext > NW'(MAX_PEOPLE)) begin
            w_n_ext = NW'(MAX_PEOPLE);
        end
        w_n_eff = IW'(w_n_ext);
    end

    assign w_sum    = SW'(r_j) + SW'(r_k);
    assign w_sum_lt = (w_sum < SW'(r_i));
    assign w_surv   = IW'(r_j) + IW'(1);

    js_mod_unit #(
        .DVD_W (SW),
        .DVS_W (IW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_sum),
        .i_divisor  (r_i),
        .o_stat     (w_stat),
        .o_rem      (w_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_rd_ptr    = r_rd_ptr;
        n_n         = r_n;
        n_k         = r_k;
        n_i         = r_i;
        n_j         = r_j;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_rd_en     = 1'b0;
        w_start     = 1'b0;
        w_adv       = 1'b0;
        w_adv_j     = r_j;
        if (w_m_acc) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (!w_empty) begin
                    w_rd_en  = 1'b1;
                    n_rd_ptr = r_rd_ptr + 1'b1;
                    n_state  = S_LOAD;
                end
            end
            S_LOAD: begin
                n_n = w_n_eff;
                n_k = (w_step == '0) ? js_pkg::STEP_W'(1) : w_step;
                n_i = IW'(2);
                n_j = '0;
                n_state = (w_n_eff == IW'(1)) ? S_DONE : S_ITER;
            end
            S_ITER: begin
                if (w_sum_lt) begin
                    w_adv   = 1'b1;
                    w_adv_j = JW'(w_sum);
                end else begin
                    w_start = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_stat.done) begin
                    w_adv   = 1'b1;
                    w_adv_j = JW'(w_rem);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = js_pkg::SURV_W'(w_surv);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_adv) begin
            n_j = w_adv_j;
            if (r_i == r_n) begin
                n_state = S_DONE;
            end else begin
                n_i     = r_i + 1'b1;
                n_state = S_ITER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_ptr    <= n_rd_ptr;
            r_out_valid <= n_out_valid;
            if (w_s_acc) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_k        <= n_k;
        r_i        <= n_i;
        r_j        <= n_j;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = js_pkg::OUT_TDATA_W'(r_out_data);

    `JS_ASSERT_IMP(a_iter_index_below_modulus, r_state == S_ITER, IW'(r_j) < r_i, "j not below i")
    `JS_ASSERT_IMP(a_queue_fill_bounded, 1'b1, PW'(r_wr_ptr - r_rd_ptr) <= PW'(js_pkg::QUEUE_DEPTH), "queue fill above depth")
    `JS_ASSERT_IMP(a_start_only_when_free, w_start, !w_stat.busy && r_i > r_n - r_n, "remainder unit restarted while busy")
    `JS_ASSERT_NXT(a_survivor_nonzero, n_out_valid && !r_out_valid, (MAX_PEOPLE > 8191) || (o_m_tdata[12:0] != '0), "survivor of zero")

endmodule

// ----- hw/rtl/js_mod_unit.sv -----
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module js_mod_unit #(
    parameter int DVD_W = 17,
    parameter int DVS_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output js_pkg::t_mod_stat o_stat,
    output logic [DVS_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0]   w_trial;
    logic             w_ge;
    logic [DVS_W-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[DVD_W-1]};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        if (w_ge) begin
            n_rem = DVS_W'(w_trial - {1'b0, r_dvs});
        end else begin
            n_rem = w_trial[DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule
